// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deque block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, off while rst_n is low.
`define BDQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising edge of clk, reset included.
`define BDQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Sizes, operation codes, register map and ring helpers for the deque block.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH     = 1024;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 11;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 3;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CAP_W-1:0]         cap_t;
  typedef logic [CMP_W-1:0]         cmp_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam cap_t CAP_RESET = cap_t'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  localparam logic REG_CAPACITY = 1'b0;

  localparam data_t EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    idx_t  raddr_a;
    idx_t  raddr_b;
  } ram_req_t;

  typedef struct packed {
    logic  ok;
    data_t front_value;
    data_t rear_value;
    logic  is_empty;
    logic  is_full;
  } result_t;

  function automatic idx_t ring_next(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t ring_prev(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
  endfunction

  function automatic logic at_limit(cnt_t c, cap_t cap);
    cmp_t cw;
    cmp_t pw;
    cw = cmp_t'(c);
    pw = cmp_t'(cap);
    return (cw >= pw) || (c == cnt_t'(DEPTH));
  endfunction

endpackage

// ----- src/bdq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque channels
// Valid/ready channels for operation requests and for results.
// ----------------------------------------------------------------------------
interface bdq_in_if;
  logic                           valid;
  logic                           ready;
  logic [bdq_pkg::OP_W-1:0]       op;
  logic signed [bdq_pkg::DATA_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink (input valid, op, value, output ready);
endinterface

interface bdq_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [bdq_pkg::DATA_W-1:0] front_value;
  logic signed [bdq_pkg::DATA_W-1:0] rear_value;
  logic                              is_empty;
  logic                              is_full;

  modport source (output valid, ok, front_value, rear_value, is_empty, is_full,
                  input ready);
  modport sink (input valid, ok, front_value, rear_value, is_empty, is_full,
                output ready);
endinterface

// ----- src/bdq_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque configuration registers
// APB-style register port holding the capacity limit.
// ----------------------------------------------------------------------------
module bdq_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bdq_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [bdq_pkg::APB_W-1:0]     cfg_pwdata,
  output logic [bdq_pkg::APB_W-1:0]     cfg_prdata,
  output logic                          cfg_pready,
  output bdq_pkg::cap_t                 capacity
);

  bdq_pkg::cap_t capacity_r;
  bdq_pkg::cap_t capacity_nxt;
  logic          sel_cap;

  assign sel_cap    = (cfg_paddr[2] == bdq_pkg::REG_CAPACITY);
  assign cfg_pready = 1'b1;
  assign capacity   = capacity_r;

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_cap) begin
      capacity_nxt = cfg_pwdata[bdq_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_cap) begin
      cfg_prdata = bdq_pkg::APB_W'(capacity_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= bdq_pkg::CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

endmodule

// ----- src/bdq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque slot store
// One write port, two registered read ports with write forwarding.
// ----------------------------------------------------------------------------
module bdq_ram (
  input  logic              clk,
  input  bdq_pkg::ram_req_t req,
  output bdq_pkg::data_t    rdata_a,
  output bdq_pkg::data_t    rdata_b
);

  bdq_pkg::data_t mem [bdq_pkg::DEPTH];
  bdq_pkg::data_t rdata_a_r;
  bdq_pkg::data_t rdata_b_r;

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr_a)) begin
      rdata_a_r <= req.wdata;
    end else begin
      rdata_a_r <= mem[req.raddr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr_b)) begin
      rdata_b_r <= req.wdata;
    end else begin
      rdata_b_r <= mem[req.raddr_b];
    end
  end

endmodule

// ----- src/bdq_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque control core
// Input register, ring index update with cached end values, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_core (
  input  logic              clk,
  input  logic              rst_n,
  bdq_in_if.sink            in_chan,
  bdq_out_if.source         out_chan,
  input  bdq_pkg::cap_t     capacity,
  output bdq_pkg::ram_req_t ram_req,
  input  bdq_pkg::data_t    sec_front,
  input  bdq_pkg::data_t    sec_rear
);

  localparam int SW = bdq_pkg::CNT_W + 1;

  logic                      in_vld_r;
  logic                      in_vld_nxt;
  logic [bdq_pkg::OP_W-1:0]  in_op_r;
  bdq_pkg::data_t            in_val_r;
  logic                      out_vld_r;
  logic                      out_vld_nxt;
  bdq_pkg::result_t          res_r;
  bdq_pkg::result_t          res_nxt;

  bdq_pkg::idx_t  front_r;
  bdq_pkg::idx_t  front_nxt;
  bdq_pkg::idx_t  rear_r;
  bdq_pkg::idx_t  rear_nxt;
  bdq_pkg::cnt_t  cnt_r;
  bdq_pkg::cnt_t  cnt_nxt;
  bdq_pkg::data_t fval_r;
  bdq_pkg::data_t fval_nxt;
  bdq_pkg::data_t rval_r;
  bdq_pkg::data_t rval_nxt;

  logic advance;
  logic go;
  logic in_acc;
  logic empty;
  logic full;
  logic empty_n;
  logic ok;
  logic [SW-1:0] ring_sum;
  logic [SW-1:0] ring_end;

  assign advance        = !out_vld_r || out_chan.ready;
  assign go             = in_vld_r && advance;
  assign in_chan.ready  = !in_vld_r || advance;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign empty          = (cnt_r == '0);
  assign full           = bdq_pkg::at_limit(cnt_r, capacity);

  always_comb begin
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    cnt_nxt       = cnt_r;
    fval_nxt      = fval_r;
    rval_nxt      = rval_r;
    ok            = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = rear_r;
    ram_req.wdata = in_val_r;
    if (go) begin
      case (in_op_r)
        bdq_pkg::OP_PUSH_FRONT: begin
          if (!full) begin
            front_nxt     = bdq_pkg::ring_prev(front_r);
            ram_req.we    = 1'b1;
            ram_req.waddr = front_nxt;
            cnt_nxt       = cnt_r + bdq_pkg::cnt_t'(1);
            fval_nxt      = in_val_r;
            rval_nxt      = empty ? in_val_r : rval_r;
            ok            = 1'b1;
          end
        end
        bdq_pkg::OP_PUSH_BACK: begin
          if (!full) begin
            rear_nxt      = bdq_pkg::ring_next(rear_r);
            ram_req.we    = 1'b1;
            ram_req.waddr = rear_r;
            cnt_nxt       = cnt_r + bdq_pkg::cnt_t'(1);
            rval_nxt      = in_val_r;
            fval_nxt      = empty ? in_val_r : fval_r;
            ok            = 1'b1;
          end
        end
        bdq_pkg::OP_POP_FRONT: begin
          if (!empty) begin
            front_nxt = bdq_pkg::ring_next(front_r);
            cnt_nxt   = cnt_r - bdq_pkg::cnt_t'(1);
            fval_nxt  = sec_front;
            ok        = 1'b1;
          end
        end
        bdq_pkg::OP_POP_BACK: begin
          if (!empty) begin
            rear_nxt = bdq_pkg::ring_prev(rear_r);
            cnt_nxt  = cnt_r - bdq_pkg::cnt_t'(1);
            rval_nxt = sec_rear;
            ok       = 1'b1;
          end
        end
        bdq_pkg::OP_QUERY: begin
          ok = 1'b1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
    ram_req.raddr_a = bdq_pkg::ring_next(front_nxt);
    ram_req.raddr_b = bdq_pkg::ring_prev(bdq_pkg::ring_prev(rear_nxt));
  end

  always_comb begin
    empty_n             = (cnt_nxt == '0);
    res_nxt.ok          = ok;
    res_nxt.front_value = empty_n ? bdq_pkg::EMPTY_VALUE : fval_nxt;
    res_nxt.rear_value  = empty_n ? bdq_pkg::EMPTY_VALUE : rval_nxt;
    res_nxt.is_empty    = empty_n;
    res_nxt.is_full     = bdq_pkg::at_limit(cnt_nxt, capacity);
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (go) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      front_r   <= '0;
      rear_r    <= '0;
      cnt_r     <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      front_r   <= front_nxt;
      rear_r    <= rear_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_op_r  <= in_chan.op;
      in_val_r <= in_chan.value;
    end
    if (go) begin
      res_r <= res_nxt;
    end
    fval_r <= fval_nxt;
    rval_r <= rval_nxt;
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.ok          = res_r.ok;
  assign out_chan.front_value = res_r.front_value;
  assign out_chan.rear_value  = res_r.rear_value;
  assign out_chan.is_empty    = res_r.is_empty;
  assign out_chan.is_full     = res_r.is_full;

  assign ring_sum = SW'(front_r) + SW'(cnt_r);
  assign ring_end = (ring_sum >= SW'(bdq_pkg::DEPTH)) ? ring_sum - SW'(bdq_pkg::DEPTH)
                                                      : ring_sum;

  `BDQ_ASSERT(a_ring_span, clk, rst_n, ring_end[bdq_pkg::IDX_W-1:0] == rear_r, "ring span mismatch")
  `BDQ_ASSERT(a_pop_empty, clk, rst_n, go && empty && (in_op_r == bdq_pkg::OP_POP_FRONT || in_op_r == bdq_pkg::OP_POP_BACK) |=> !res_r.ok, "pop on empty reported ok")
  `BDQ_ASSERT(a_count_step, clk, rst_n, go |=> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + bdq_pkg::cnt_t'(1) || cnt_r == $past(cnt_r) - bdq_pkg::cnt_t'(1)), "count jumped")
  `BDQ_ASSERT(a_count_hold, clk, rst_n, !go |=> $stable(cnt_r), "count moved without transaction")
  `BDQ_ASSERT(a_empty_flag, clk, rst_n, out_vld_r |-> (res_r.is_empty == (cnt_r == '0)), "empty flag out of step")

endmodule

// ----- src/bounded_double_ended_queue_unit.sv -----
// An accepted transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while results are taken; ends are cached,
// next-inner slots are prefetched on the store's two registered read ports.
// Reset: synchronous active-low rst_n empties the queue and sets capacity to 1024.
// Slot store contents are not cleared; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended queue unit
// Ring-store deque with push/pop at both ends and an APB capacity register.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  bdq_in_if.sink                        in_chan,
  bdq_out_if.source                     out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bdq_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [bdq_pkg::APB_W-1:0]     cfg_pwdata,
  output logic [bdq_pkg::APB_W-1:0]     cfg_prdata,
  output logic                          cfg_pready
);

  bdq_pkg::cap_t     capacity;
  bdq_pkg::ram_req_t ram_req;
  bdq_pkg::data_t    sec_front;
  bdq_pkg::data_t    sec_rear;

  bdq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .capacity    (capacity)
  );

  bdq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rdata_a (sec_front),
    .rdata_b (sec_rear)
  );

  bdq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .capacity  (capacity),
    .ram_req   (ram_req),
    .sec_front (sec_front),
    .sec_rear  (sec_rear)
  );

endmodule

// ----- dv/bounded_double_ended_queue_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended queue unit testbench
// Sends push, pop and query transactions to the deque and checks every result
// against a queue-based model of the ring store. Capacity settings are swept
// from zero past the store depth. Sender gaps, receiver stalls and long
// receiver hold-offs vary from phase to phase.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_unit_test;

  typedef struct {
    logic [bdq_pkg::OP_W-1:0] op;
    bdq_pkg::data_t           value;
  } deque_req_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [bdq_pkg::PADDR_W-1:0] cfg_paddr = '0;
  logic [bdq_pkg::APB_W-1:0]   cfg_pwdata = '0;
  logic [bdq_pkg::APB_W-1:0]   cfg_prdata;
  logic                        cfg_pready;

  bdq_in_if  in_chan();
  bdq_out_if out_chan();

  deque_req_t         req_backlog[$];
  bdq_pkg::result_t   expected_results[$];
  bdq_pkg::data_t     deque_contents[$];
  bdq_pkg::cap_t      capacity_setting = bdq_pkg::CAP_RESET;
  int                 error_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_token = 0;
  int                 hold_seen = 0;
  int                 hold_len = 0;
  int                 hold_left = 0;
  int unsigned sweep_caps[9] = '{2, 5, 1, 8, 17, 64, 1024, 2047, 3};

  always #2 clk = ~clk;

  bounded_double_ended_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic bdq_pkg::result_t predict_result(logic [bdq_pkg::OP_W-1:0] op,
                                                      bdq_pkg::data_t value);
    bdq_pkg::result_t r;
    int               limit;
    logic             full_now;
    logic             empty_now;
    limit = (capacity_setting > bdq_pkg::cap_t'(bdq_pkg::DEPTH)) ? bdq_pkg::DEPTH
                                                                 : int'(capacity_setting);
    full_now = deque_contents.size() >= limit;
    empty_now = deque_contents.size() == 0;
    r.ok = 1'b0;
    case (op)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (!full_now) begin
          deque_contents.push_front(value);
          r.ok = 1'b1;
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (!full_now) begin
          deque_contents.push_back(value);
          r.ok = 1'b1;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (!empty_now) begin
          void'(deque_contents.pop_front());
          r.ok = 1'b1;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (!empty_now) begin
          void'(deque_contents.pop_back());
          r.ok = 1'b1;
        end
      end
      bdq_pkg::OP_QUERY: r.ok = 1'b1;
      default: r.ok = 1'b0;
    endcase
    r.is_empty = deque_contents.size() == 0;
    r.is_full = deque_contents.size() >= limit;
    r.front_value = r.is_empty ? bdq_pkg::EMPTY_VALUE : deque_contents[0];
    r.rear_value = r.is_empty ? bdq_pkg::EMPTY_VALUE : deque_contents[$];
    return r;
  endfunction

  function automatic bdq_pkg::data_t pick_value();
    case ($urandom_range(0, 9))
      0: return bdq_pkg::data_t'(32'h8000_0000);
      1: return bdq_pkg::data_t'(32'h7FFF_FFFF);
      2: return bdq_pkg::data_t'(32'hFFFF_FFFF);
      3: return bdq_pkg::data_t'(32'h0000_0000);
      default: return bdq_pkg::data_t'($urandom);
    endcase
  endfunction

  function automatic void queue_req(logic [bdq_pkg::OP_W-1:0] op, bdq_pkg::data_t value);
    req_backlog.push_back(deque_req_t'{op, value});
  endfunction

  function automatic logic [bdq_pkg::OP_W-1:0] pick_push();
    return $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
  endfunction

  function automatic logic [bdq_pkg::OP_W-1:0] pick_raw();
    return bdq_pkg::OP_W'($urandom_range(0, 7));
  endfunction

  // Runs of pushes, runs of pops, and some raw codes including unknown ones, with queries mixed in.
  task automatic queue_runs(int n);
    int                       run_kind;
    int                       run_len;
    logic [bdq_pkg::OP_W-1:0] op;
    while (n > 0) begin
      run_kind = $urandom_range(0, 99);
      run_len = $urandom_range(1, 12);
      for (int k = 0; k < run_len && n > 0; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          op = bdq_pkg::OP_QUERY;
        end else if (run_kind < 45) begin
          op = pick_push();
        end else if (run_kind < 85) begin
          op = $urandom_range(0, 1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
        end else begin
          op = pick_raw();
        end
        queue_req(op, pick_value());
        n--;
      end
    end
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  task automatic request_hold(int unsigned len);
    hold_len = len;
    hold_token++;
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_chan.valid === 1'b1 ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the capacity register, then read it back.
  task automatic write_capacity(int unsigned cap_value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= bdq_pkg::PADDR_W'(4 * bdq_pkg::REG_CAPACITY);
    cfg_pwdata <= bdq_pkg::APB_W'(cap_value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    capacity_setting = bdq_pkg::cap_t'(cap_value);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    if (cfg_prdata[bdq_pkg::CAP_W-1:0] !== capacity_setting)
      report_mismatch($sformatf("capacity read back %0d, wrote %0d",
                                cfg_prdata[bdq_pkg::CAP_W-1:0], capacity_setting));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  always @(posedge clk) begin : request_driver
    deque_req_t next_req;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.op <= '0;
      in_chan.value <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        expected_results.push_back(predict_result(in_chan.op, in_chan.value));
      if (!in_chan.valid || in_chan.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = req_backlog.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.op <= next_req.op;
          in_chan.value <= next_req.value;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    bdq_pkg::result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_chan.ok !== want.ok)
            report_mismatch($sformatf("ok %b, want %b", out_chan.ok, want.ok));
          if (out_chan.front_value !== want.front_value)
            report_mismatch($sformatf("front_value %0d, want %0d",
                                      out_chan.front_value, want.front_value));
          if (out_chan.rear_value !== want.rear_value)
            report_mismatch($sformatf("rear_value %0d, want %0d",
                                      out_chan.rear_value, want.rear_value));
          if (out_chan.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %b, want %b",
                                      out_chan.is_empty, want.is_empty));
          if (out_chan.is_full !== want.is_full)
            report_mismatch($sformatf("is_full %b, want %b",
                                      out_chan.is_full, want.is_full));
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= hold_len;
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("bounded_double_ended_queue_unit_test: errors");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // Empty queue at reset capacity, unknown codes, value extremes at both ends.
    queue_req(bdq_pkg::OP_QUERY, 32'sd0);
    queue_req(bdq_pkg::OP_POP_FRONT, 32'sd0);
    queue_req(bdq_pkg::OP_POP_BACK, 32'sd0);
    queue_req(3'd5, 32'sd7);
    queue_req(3'd6, 32'sd0);
    queue_req(3'd7, -32'sd1);
    queue_req(bdq_pkg::OP_PUSH_FRONT, bdq_pkg::data_t'(32'h8000_0000));
    queue_req(bdq_pkg::OP_PUSH_BACK, bdq_pkg::data_t'(32'h7FFF_FFFF));
    queue_req(bdq_pkg::OP_PUSH_FRONT, -32'sd1);
    queue_req(bdq_pkg::OP_PUSH_BACK, 32'sd0);
    queue_req(bdq_pkg::OP_QUERY, 32'sd0);
    queue_req(bdq_pkg::OP_POP_FRONT, 32'sd0);
    queue_req(bdq_pkg::OP_POP_BACK, 32'sd0);
    queue_req(bdq_pkg::OP_POP_FRONT, 32'sd0);
    queue_req(bdq_pkg::OP_POP_BACK, 32'sd0);
    queue_req(bdq_pkg::OP_POP_FRONT, 32'sd0);
    wait_drained();

    // Zero capacity: refuse all pushes, full and empty together.
    write_capacity(0);
    queue_req(bdq_pkg::OP_PUSH_FRONT, 32'sd1);
    queue_req(bdq_pkg::OP_PUSH_BACK, 32'sd2);
    queue_req(bdq_pkg::OP_QUERY, 32'sd0);
    wait_drained();

    write_capacity(1);
    queue_req(bdq_pkg::OP_PUSH_BACK, bdq_pkg::data_t'(32'h5555_5555));
    queue_req(bdq_pkg::OP_PUSH_FRONT, bdq_pkg::data_t'(32'h2AAA_AAAA));
    queue_req(bdq_pkg::OP_POP_BACK, 32'sd0);
    queue_req(bdq_pkg::OP_PUSH_FRONT, bdq_pkg::data_t'(32'hAAAA_AAAA));
    queue_req(bdq_pkg::OP_POP_FRONT, 32'sd0);
    wait_drained();

    foreach (sweep_caps[i]) begin
      write_capacity(sweep_caps[i]);
      set_idling(i);
      queue_runs(25);
      request_hold($urandom_range(64, 300));
      wait_drained();
      queue_runs(25);
      wait_drained();
    end

    // Fill the whole store with capacity above its depth, then push past full.
    write_capacity(2047);
    set_idling(3);
    for (int k = 0; k < bdq_pkg::DEPTH; k++) begin
      if ($urandom_range(0, 49) == 0)
        queue_req(bdq_pkg::OP_QUERY, pick_value());
      queue_req(pick_push(), pick_value());
    end
    request_hold(300);
    for (int k = 0; k < 24; k++)
      queue_req($urandom_range(0, 1) ? pick_push() : pick_raw(), pick_value());
    wait_drained();

    // Capacity dropped below the held count.
    write_capacity(3);
    set_idling(1);
    queue_runs(30);
    wait_drained();

    write_capacity(0);
    set_idling(2);
    queue_runs(10);
    wait_drained();

    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("bounded_double_ended_queue_unit_test: clean");
    end else begin
      $display("bounded_double_ended_queue_unit_test: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/bdq_pkg.sv
src/bdq_if.sv
src/bdq_cfg.sv
src/bdq_ram.sv
src/bdq_core.sv
src/bounded_double_ended_queue_unit.sv
dv/bounded_double_ended_queue_unit_test.sv
